// ===== hw/rtl/dswc_pkg.sv =====
// Shared types and constants for the daily schedule window checker.
// Used by dswc_cell and daily_schedule_window_checker; depends on nothing.
package dswc_pkg;

  localparam int unsigned MIN_W  = 11;
  localparam int unsigned SLOT_W = 4;
  localparam int unsigned CFG_W  = 8;
  localparam int unsigned CIDX_W = 2;

  localparam logic [MIN_W-1:0] DAY_MINS = 11'd1440;

  // configuration register indexes
  localparam logic [CIDX_W-1:0] CFG_PREWARM = 2'd0;
  localparam logic [CIDX_W-1:0] CFG_ECO     = 2'd1;
  localparam logic [CIDX_W-1:0] CFG_COMFORT = 2'd2;

  localparam logic [CFG_W-1:0] PREWARM_RST = 8'd18;
  localparam logic [CFG_W-1:0] ECO_RST     = 8'd60;
  localparam logic [CFG_W-1:0] COMFORT_RST = 8'd120;

  // warmth classes; every other code takes the mean
  localparam logic [1:0] WARM_ECO     = 2'd0;
  localparam logic [1:0] WARM_COMFORT = 2'd1;

  typedef enum logic [1:0] {
    CMD_QUERY = 2'd0,
    CMD_SET   = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_READ  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FIX,
    ST_RUN,
    ST_DONE
  } state_t;

  // request as it travels down the row of cells
  typedef struct packed {
    cmd_t              cmd;
    logic [SLOT_W-1:0] slot;
    logic [MIN_W-1:0]  mins;
    logic [MIN_W-1:0]  ahead;
    logic [CFG_W-1:0]  period;
    logic              min_ok;
    logic [MIN_W-1:0]  start;
    logic              ok;
    logic              any;
    logic              now;
    logic              soon;
    logic              sset;
    logic [MIN_W-1:0]  on_t;
    logic [MIN_W-1:0]  off_t;
  } pkt_t;

endpackage

// ===== hw/rtl/dswc_cell.sv =====
// One schedule slot: holds its start minute and evaluates the passing request.
// Depends on dswc_pkg.
module dswc_cell
  import dswc_pkg::*;
#(
  parameter int unsigned IDX = 0
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [CFG_W-1:0] prewarm,
  input  logic             in_vld,
  input  pkt_t             in_pkt,
  output logic             out_vld,
  output pkt_t             out_pkt
);

  logic             valid_r, valid_nxt;
  logic [MIN_W-1:0] start_r, start_nxt;
  logic             vld_r;
  pkt_t             pkt_r, pkt_nxt;

  logic             hit;
  logic [MIN_W:0]   on_diff;
  logic [MIN_W-1:0] on_min;
  logic [MIN_W-1:0] off_sum;
  logic [MIN_W-1:0] off_min;

  function automatic logic in_window(input logic [MIN_W-1:0] m,
                                     input logic [MIN_W-1:0] s,
                                     input logic [MIN_W-1:0] f);
    if (f < s) begin
      return (m >= s) || (m < f);
    end
    return (m >= s) && (m < f);
  endfunction

  assign hit = (in_pkt.slot == SLOT_W'(IDX));

  // open = start - prewarm, wrapped into the day
  assign on_diff = {1'b0, start_r} - {{(MIN_W + 1 - CFG_W){1'b0}}, prewarm};
  assign on_min  = on_diff[MIN_W] ? (on_diff[MIN_W-1:0] + DAY_MINS) : on_diff[MIN_W-1:0];

  // close = start + on period, wrapped into the day
  assign off_sum = start_r + {{(MIN_W - CFG_W){1'b0}}, in_pkt.period};
  assign off_min = (off_sum >= DAY_MINS) ? (off_sum - DAY_MINS) : off_sum;

  always_comb begin
    pkt_nxt   = in_pkt;
    valid_nxt = valid_r;
    start_nxt = start_r;
    if (in_vld) begin
      case (in_pkt.cmd)
        CMD_QUERY: begin
          if (valid_r && in_pkt.min_ok) begin
            pkt_nxt.now  = in_pkt.now  | in_window(in_pkt.mins,  on_min, off_min);
            pkt_nxt.soon = in_pkt.soon | in_window(in_pkt.ahead, on_min, off_min);
          end
        end
        CMD_SET: begin
          if (hit && in_pkt.min_ok) begin
            valid_nxt = 1'b1;
            start_nxt = in_pkt.start;
          end
        end
        CMD_CLEAR: begin
          if (hit) begin
            valid_nxt = 1'b0;
          end
        end
        CMD_READ: begin
          if (hit && valid_r) begin
            pkt_nxt.sset  = 1'b1;
            pkt_nxt.on_t  = on_min;
            pkt_nxt.off_t = off_min;
          end
        end
        default: ;
      endcase
    end
    pkt_nxt.any = in_pkt.any | valid_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      vld_r   <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      vld_r   <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    start_r <= start_nxt;
    pkt_r   <= pkt_nxt;
  end

  assign out_vld = vld_r;
  assign out_pkt = pkt_r;

endmodule

// ===== hw/rtl/daily_schedule_window_checker.sv =====
// Top level of the daily schedule window checker: input capture, start-minute
// rounding, request injection and result register. Depends on dswc_pkg, dswc_cell.
//
// Each request (query, set, clear or read of a slot) passes once along a row of
// SLOT_COUNT cells, one cell per cycle, each holding one slot's start minute and
// folding its window test into the request. The request is captured, its start
// minute is rounded and the packet is injected into the row, it is registered in
// each cell in turn, collected from the tail of the row and then loaded into the
// output register. Only one request is in flight at a time, and the row length
// sets how long each one takes. The next item is taken once that result has moved
// into the output register, which can still be waiting on the far side.
// The slot store comes out of reset all unset; no clearing pass is needed.
module daily_schedule_window_checker
  import dswc_pkg::*;
#(
  parameter int unsigned SLOT_COUNT       = 4,
  parameter int unsigned GRANULARITY_MINS = 6
) (
  input  logic              clk,
  input  logic              rst_n,

  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        in_cmd,
  input  logic [SLOT_W-1:0] in_slot,
  input  logic [MIN_W-1:0]  in_minutes,
  input  logic [1:0]        in_warmth_class,

  output logic              out_valid,
  input  logic              out_stall,
  output logic              out_ok,
  output logic              out_slot_set,
  output logic [MIN_W-1:0]  out_on_time,
  output logic [MIN_W-1:0]  out_off_time,
  output logic              out_any_set,
  output logic              out_on_now,
  output logic              out_on_soon,

  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [CIDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]  cfg_data
);

  // floor(m / G) by reciprocal: estimate is exact or one low for m < 2**DIV_SHIFT
  localparam int unsigned DIV_SHIFT = 16;
  localparam int unsigned RECIP     = (1 << DIV_SHIFT) / GRANULARITY_MINS;
  localparam int unsigned RECIP_W   = $clog2(RECIP + 1);
  localparam int unsigned PROD_W    = MIN_W + RECIP_W;
  localparam int unsigned Q_W       = PROD_W - DIV_SHIFT;
  localparam logic [RECIP_W-1:0] RECIP_V = RECIP_W'(RECIP);
  localparam logic [MIN_W-1:0]   GRAN_V  = MIN_W'(GRANULARITY_MINS);
  localparam logic [SLOT_W:0]    SLOTS_V = (SLOT_W + 1)'(SLOT_COUNT);

  state_t state_r, state_nxt;

  logic [CFG_W-1:0] prewarm_r, eco_r, comfort_r;

  cmd_t              cmd_r;
  logic [SLOT_W-1:0] slot_r;
  logic [MIN_W-1:0]  min_r;
  logic [1:0]        cls_r;
  logic [PROD_W-1:0] prod_r, prod_nxt;

  logic              pkt_vld_r, pkt_vld_nxt;
  pkt_t              pkt_r, pkt_nxt;
  pkt_t              tail_r;

  logic              out_valid_r, out_valid_nxt;
  pkt_t              res_r;

  logic              in_take;
  logic              out_load;
  logic              slot_ok, min_ok;
  logic [Q_W-1:0]    q0;
  logic [MIN_W-1:0]  q0_mul;
  logic [MIN_W-1:0]  rem;
  logic [MIN_W-1:0]  start_min;
  logic [MIN_W:0]    ahead_sum;
  logic [CFG_W:0]    mean_sum;
  logic [CFG_W-1:0]  period;

  logic              chain_vld [SLOT_COUNT+1];
  pkt_t              chain_pkt [SLOT_COUNT+1];

  // configuration
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prewarm_r <= PREWARM_RST;
      eco_r     <= ECO_RST;
      comfort_r <= COMFORT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_PREWARM: prewarm_r <= cfg_data;
        CFG_ECO:     eco_r     <= cfg_data;
        CFG_COMFORT: comfort_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // capture the request and start the reciprocal multiply
  assign in_stall = (state_r != ST_IDLE);
  assign in_take  = in_valid && !in_stall;
  assign prod_nxt = {{RECIP_W{1'b0}}, in_minutes} * {{MIN_W{1'b0}}, RECIP_V};

  always_ff @(posedge clk) begin
    if (in_take) begin
      cmd_r  <= cmd_t'(in_cmd);
      slot_r <= in_slot;
      min_r  <= in_minutes;
      cls_r  <= in_warmth_class;
      prod_r <= prod_nxt;
    end
  end

  // round the start minute down to the granularity
  assign q0        = prod_r[PROD_W-1:DIV_SHIFT];
  assign q0_mul    = MIN_W'(q0 * GRAN_V);
  assign rem       = min_r - q0_mul;
  assign start_min = (rem >= GRAN_V) ? (q0_mul + GRAN_V) : q0_mul;

  assign slot_ok   = ({1'b0, slot_r} < SLOTS_V);
  assign min_ok    = (min_r < DAY_MINS);
  assign ahead_sum = {1'b0, min_r} + {{(MIN_W + 1 - CFG_W){1'b0}}, prewarm_r};
  assign mean_sum  = {1'b0, eco_r} + {1'b0, comfort_r};

  always_comb begin
    case (cls_r)
      WARM_ECO:     period = eco_r;
      WARM_COMFORT: period = comfort_r;
      default:      period = mean_sum[CFG_W:1];
    endcase
  end

  always_comb begin
    pkt_nxt        = '0;
    pkt_nxt.cmd    = cmd_r;
    pkt_nxt.slot   = slot_r;
    pkt_nxt.mins   = min_r;
    pkt_nxt.ahead  = (ahead_sum >= {1'b0, DAY_MINS}) ?
                     MIN_W'(ahead_sum - {1'b0, DAY_MINS}) : ahead_sum[MIN_W-1:0];
    pkt_nxt.period = period;
    pkt_nxt.min_ok = min_ok;
    pkt_nxt.start  = start_min;
    case (cmd_r)
      CMD_QUERY: pkt_nxt.ok = min_ok;
      CMD_SET:   pkt_nxt.ok = slot_ok && min_ok;
      CMD_CLEAR: pkt_nxt.ok = slot_ok;
      CMD_READ:  pkt_nxt.ok = slot_ok;
      default:   pkt_nxt.ok = 1'b0;
    endcase
  end

  // sequencer
  assign out_load = (state_r == ST_DONE) && (!out_valid_r || !out_stall);

  always_comb begin
    state_nxt   = state_r;
    pkt_vld_nxt = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_take) begin
          state_nxt = ST_FIX;
        end
      end
      ST_FIX: begin
        pkt_vld_nxt = 1'b1;
        state_nxt   = ST_RUN;
      end
      ST_RUN: begin
        if (chain_vld[SLOT_COUNT]) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      pkt_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      pkt_vld_r <= pkt_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_FIX) begin
      pkt_r <= pkt_nxt;
    end
    if (chain_vld[SLOT_COUNT]) begin
      tail_r <= chain_pkt[SLOT_COUNT];
    end
  end

  // row of slot cells
  assign chain_vld[0] = pkt_vld_r;
  assign chain_pkt[0] = pkt_r;

  for (genvar i = 0; i < SLOT_COUNT; i++) begin : g_cell
    dswc_cell #(
      .IDX (i)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .prewarm (prewarm_r),
      .in_vld  (chain_vld[i]),
      .in_pkt  (chain_pkt[i]),
      .out_vld (chain_vld[i+1]),
      .out_pkt (chain_pkt[i+1])
    );
  end

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      res_r <= tail_r;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_ok       = res_r.ok;
  assign out_slot_set = res_r.sset;
  assign out_on_time  = res_r.on_t;
  assign out_off_time = res_r.off_t;
  assign out_any_set  = res_r.any;
  assign out_on_now   = res_r.now;
  assign out_on_soon  = res_r.soon;

endmodule
